[rtl/lapi_pkg.sv]
package lapi_pkg;

    localparam int CAPACITY     = 8192;
    localparam int MAX_STEPS    = 64;
    localparam int IDX_W        = 13;
    localparam int NEXT_W       = 14;
    localparam int HALF_TURN    = 180;
    localparam int FULL_TURN    = 360;
    localparam int CORDIC_ITERS = 24;

    localparam logic [33:0] PI_Q32   = 34'd13493037705;
    localparam logic [29:0] GAIN_Q30 = 30'd652032875;

    // serial multiplier: a is held, b is consumed one bit per cycle
    localparam int SMUL_AW = 34;
    localparam int SMUL_BW = 26;
    localparam int SMUL_PW = SMUL_AW + SMUL_BW;

    // serial divider: one quotient bit per cycle
    localparam int SDIV_NW = 48;
    localparam int SDIV_DW = 15;

    localparam int CRD_W  = 36;
    localparam int CRD_ZW = 34;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_HMUL,
        S_HDIV,
        S_GMX,
        S_GMY,
        S_PNT,
        S_AMUL,
        S_ADIV,
        S_ROT,
        S_LMX,
        S_LDX,
        S_LMY,
        S_LDY,
        S_EMIT
    } t_state;

    // arctangent of 2^-k as a binary angle, 2^32 to the turn
    function automatic logic [29:0] f_atan(input logic [4:0] k);
        logic [29:0] v;
        unique case (k)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/lapi_smul.sv]
module lapi_smul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lapi_pkg::SMUL_AW-1:0]  i_a,
    input  logic [lapi_pkg::SMUL_BW-1:0]  i_b,
    output logic                          o_done,
    output logic [lapi_pkg::SMUL_PW-1:0]  o_p
);
    import lapi_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [4:0]           r_cnt;
    logic [SMUL_AW-1:0]   r_a;
    logic [SMUL_PW-1:0]   r_p;
    logic [SMUL_AW:0]     w_upper;

    // low half holds the remaining multiplier bits, high half the partial sum
    assign w_upper = {1'b0, r_p[SMUL_PW-1:SMUL_BW]} + (r_p[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(SMUL_BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{SMUL_AW{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= {w_upper, r_p[SMUL_BW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

[rtl/lapi_sdiv.sv]
module lapi_sdiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lapi_pkg::SDIV_NW-1:0]  i_num,
    input  logic [lapi_pkg::SDIV_DW-1:0]  i_den,
    output logic                          o_done,
    output logic [lapi_pkg::SDIV_NW-1:0]  o_q
);
    import lapi_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [5:0]           r_cnt;
    logic [SDIV_DW-1:0]   r_den;
    logic [SDIV_DW-1:0]   r_rem;
    logic [SDIV_NW-1:0]   r_q;
    logic [SDIV_DW:0]     w_trial;
    logic [SDIV_DW:0]     w_diff;
    logic                 w_ge;

    // restoring step: dividend bits leave at the top, quotient bits enter at the bottom
    assign w_trial = {r_rem, r_q[SDIV_NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(SDIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[SDIV_DW-1:0] : w_trial[SDIV_DW-1:0];
            r_q   <= {r_q[SDIV_NW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

[rtl/lapi_cordic.sv]
module lapi_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [lapi_pkg::CRD_W-1:0]  i_x,
    input  logic signed [lapi_pkg::CRD_W-1:0]  i_y,
    input  logic [31:0]                        i_ang,
    output logic                               o_done,
    output logic signed [lapi_pkg::CRD_W-1:0]  o_x,
    output logic signed [lapi_pkg::CRD_W-1:0]  o_y
);
    import lapi_pkg::*;

    logic                     r_busy;
    logic                     r_done;
    logic [4:0]               r_k;
    logic signed [CRD_W-1:0]  r_x;
    logic signed [CRD_W-1:0]  r_y;
    logic signed [CRD_ZW-1:0] r_z;
    logic signed [CRD_W-1:0]  w_xs;
    logic signed [CRD_W-1:0]  w_ys;
    logic signed [CRD_ZW-1:0] w_at;
    logic [31:0]              w_quad;
    logic                     w_flip;
    logic [31:0]              w_ang;

    // half-turn pre-rotation keeps the residual angle within a quarter turn
    assign w_quad = i_ang + 32'h4000_0000;
    assign w_flip = w_quad[31];
    assign w_ang  = w_flip ? {~i_ang[31], i_ang[30:0]} : i_ang;

    assign w_xs = r_x >>> r_k;
    assign w_ys = r_y >>> r_k;
    assign w_at = CRD_ZW'(f_atan(r_k));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 5'd1;
                if (r_k == 5'(CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= w_flip ? -i_x : i_x;
            r_y <= w_flip ? -i_y : i_y;
            r_z <= {{(CRD_ZW-32){w_ang[31]}}, w_ang};
        end else if (r_busy) begin
            if (!r_z[CRD_ZW-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

[rtl/line_arc_path_interpolator_core.sv]
// each line point runs two multiplies and two divides, each arc point a multiply, a divide
// and 24 cordic iterations; an arc segment first runs a heading multiply and divide and two
// gain multiplies. the bit-serial multiplier and divider, shared by the line and arc paths,
// set the pace. the next segment is taken once the last point sits in the output register.
// synchronous active-low reset clears heading to zero, the table index to one and all
// handshake state.
module line_arc_path_interpolator_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // step_count, first_x, first_y, second_x, second_y, sweep_angle, rotate_heading, pad
    input  logic [135:0]  i_s_tdata,
    // operation
    input  logic [0:0]    i_s_tuser,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // point_x, point_y, heading, point_index, overflow, pad
    output logic [95:0]   o_m_tdata,
    output logic          o_m_tlast
);
    import lapi_pkg::*;

    t_state r_state, n_state;

    logic                     r_op;
    logic                     r_rot;
    logic [6:0]               r_n;
    logic [6:0]               r_i;
    logic signed [23:0]       r_ax;
    logic signed [23:0]       r_ay;
    logic signed [24:0]       r_dx;
    logic signed [24:0]       r_dy;
    logic signed [25:0]       r_sw;
    logic [31:0]              r_hstep;
    logic signed [CRD_W-1:0]  r_x0;
    logic signed [CRD_W-1:0]  r_y0;
    logic [23:0]              r_px;
    logic [23:0]              r_py;
    logic [31:0]              r_head;
    logic [NEXT_W-1:0]        r_next;
    logic                     r_m_valid;
    logic [95:0]              r_m_data;
    logic                     r_m_last;

    logic [6:0]               w_st;
    logic [6:0]               w_n;
    logic [24:0]              w_adx;
    logic [24:0]              w_ady;
    logic [25:0]              w_asw;
    logic [SDIV_DW-1:0]       w_n90;
    logic [SDIV_DW-1:0]       w_n180;
    logic [SDIV_DW-1:0]       w_n360;

    logic                     w_mul_start;
    logic [SMUL_AW-1:0]       w_mul_a;
    logic [SMUL_BW-1:0]       w_mul_b;
    logic                     w_mul_done;
    logic [SMUL_PW-1:0]       w_mul_p;
    logic                     w_div_start;
    logic [SDIV_NW-1:0]       w_div_num;
    logic [SDIV_DW-1:0]       w_div_den;
    logic                     w_div_done;
    logic [SDIV_NW-1:0]       w_div_q;
    logic                     w_rot_start;
    logic [31:0]              w_rot_ang;
    logic                     w_rot_done;
    logic signed [CRD_W-1:0]  w_rot_x;
    logic signed [CRD_W-1:0]  w_rot_y;

    logic                     w_emit;
    logic                     w_accept;
    logic [SMUL_PW-1:0]       w_gsum;
    logic [CRD_W-1:0]         w_gmag;
    logic                     w_full;
    logic [IDX_W-1:0]         w_idx;
    logic [31:0]              w_head_new;

    function automatic logic signed [27:0] f_round8(input logic signed [CRD_W-1:0] v);
        logic [CRD_W-1:0] m;
        logic [CRD_W-1:0] s;
        m = v[CRD_W-1] ? CRD_W'(-v) : CRD_W'(v);
        s = (m + CRD_W'(128)) >> 8;
        return v[CRD_W-1] ? -28'(s) : 28'(s);
    endfunction

    function automatic logic [23:0] f_sat24(input logic signed [27:0] v);
        logic [23:0] r;
        if (v > 28'sd8388607) begin
            r = 24'h7F_FFFF;
        end else if (v < -28'sd8388608) begin
            r = 24'h80_0000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    assign w_st = i_s_tdata[6:0];
    assign w_n  = (w_st == 7'd0) ? 7'd1 :
                  (w_st > 7'(MAX_STEPS)) ? 7'(MAX_STEPS) : w_st;

    assign w_adx = r_dx[24] ? 25'(-r_dx) : 25'(r_dx);
    assign w_ady = r_dy[24] ? 25'(-r_dy) : 25'(r_dy);
    assign w_asw = r_sw[25] ? 26'(-r_sw) : 26'(r_sw);

    assign w_n90  = SDIV_DW'(r_n) * SDIV_DW'(HALF_TURN / 2);
    assign w_n180 = SDIV_DW'(r_n) * SDIV_DW'(HALF_TURN);
    assign w_n360 = SDIV_DW'(r_n) * SDIV_DW'(FULL_TURN);

    assign w_accept = i_s_tvalid && o_s_tready;

    // offset times gain, rounded from Q30 to Q8
    assign w_gsum = w_mul_p + SMUL_PW'(2097152);
    assign w_gmag = CRD_W'(w_gsum[SMUL_PW-1:22]);

    assign w_full     = r_next >= NEXT_W'(CAPACITY);
    assign w_idx      = w_full ? IDX_W'(CAPACITY - 1) : r_next[IDX_W-1:0];
    assign w_head_new = (r_op && r_rot) ? r_head + r_hstep : r_head;

    lapi_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    lapi_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    lapi_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rot_start),
        .i_x     (r_x0),
        .i_y     (r_y0),
        .i_ang   (w_rot_ang),
        .o_done  (w_rot_done),
        .o_x     (w_rot_x),
        .o_y     (w_rot_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_mul_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        w_rot_start = 1'b0;
        w_rot_ang   = '0;
        w_emit      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (r_op) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = PI_Q32;
                    w_mul_b     = w_asw;
                    n_state     = S_HMUL;
                end else begin
                    n_state = S_PNT;
                end
            end
            S_HMUL: begin
                if (w_mul_done) begin
                    // add half the divisor above bit 32, then drop the 2^32 factor
                    w_div_start = 1'b1;
                    w_div_num   = SDIV_NW'(w_mul_p[SMUL_PW-1:32]) + SDIV_NW'(w_n90);
                    w_div_den   = w_n180;
                    n_state     = S_HDIV;
                end
            end
            S_HDIV: begin
                if (w_div_done) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = SMUL_AW'(GAIN_Q30);
                    w_mul_b     = SMUL_BW'(w_adx);
                    n_state     = S_GMX;
                end
            end
            S_GMX: begin
                if (w_mul_done) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = SMUL_AW'(GAIN_Q30);
                    w_mul_b     = SMUL_BW'(w_ady);
                    n_state     = S_GMY;
                end
            end
            S_GMY: begin
                if (w_mul_done) n_state = S_PNT;
            end
            S_PNT: begin
                w_mul_start = 1'b1;
                w_mul_b     = SMUL_BW'(r_i);
                if (r_op) begin
                    w_mul_a = SMUL_AW'(w_asw);
                    n_state = S_AMUL;
                end else begin
                    w_mul_a = SMUL_AW'(w_adx);
                    n_state = S_LMX;
                end
            end
            S_AMUL: begin
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    w_div_num   = {w_mul_p[31:0], 16'h0000} + SDIV_NW'(w_n180);
                    w_div_den   = w_n360;
                    n_state     = S_ADIV;
                end
            end
            S_ADIV: begin
                if (w_div_done) begin
                    w_rot_start = 1'b1;
                    w_rot_ang   = r_sw[25] ? -w_div_q[31:0] : w_div_q[31:0];
                    n_state     = S_ROT;
                end
            end
            S_ROT: begin
                if (w_rot_done) n_state = S_EMIT;
            end
            S_LMX: begin
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    w_div_num   = SDIV_NW'(w_mul_p[30:0]) + SDIV_NW'(r_n >> 1);
                    w_div_den   = SDIV_DW'(r_n);
                    n_state     = S_LDX;
                end
            end
            S_LDX: begin
                if (w_div_done) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = SMUL_AW'(w_ady);
                    w_mul_b     = SMUL_BW'(r_i);
                    n_state     = S_LMY;
                end
            end
            S_LMY: begin
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    w_div_num   = SDIV_NW'(w_mul_p[30:0]) + SDIV_NW'(r_n >> 1);
                    w_div_den   = SDIV_DW'(r_n);
                    n_state     = S_LDY;
                end
            end
            S_LDY: begin
                if (w_div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_m_valid || i_m_tready) begin
                    w_emit  = 1'b1;
                    n_state = (r_i == r_n) ? S_IDLE : S_PNT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // segment fields and working values
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_s_tuser[0];
            r_n   <= w_n;
            r_ax  <= i_s_tdata[30:7];
            r_ay  <= i_s_tdata[54:31];
            r_dx  <= 25'(signed'(i_s_tdata[78:55])) - 25'(signed'(i_s_tdata[30:7]));
            r_dy  <= 25'(signed'(i_s_tdata[102:79])) - 25'(signed'(i_s_tdata[54:31]));
            r_sw  <= i_s_tdata[128:103];
            r_rot <= i_s_tdata[129];
        end
        if (r_state == S_LOAD) r_i <= 7'd1;
        if (w_emit) r_i <= r_i + 7'd1;
        if (r_state == S_HDIV && w_div_done) begin
            r_hstep <= r_sw[25] ? -w_div_q[31:0] : w_div_q[31:0];
        end
        if (r_state == S_GMX && w_mul_done) begin
            r_x0 <= r_dx[24] ? -w_gmag : w_gmag;
        end
        if (r_state == S_GMY && w_mul_done) begin
            r_y0 <= r_dy[24] ? -w_gmag : w_gmag;
        end
        if (r_state == S_ROT && w_rot_done) begin
            r_px <= f_sat24(28'(r_ax) + f_round8(w_rot_x));
            r_py <= f_sat24(28'(r_ay) + f_round8(w_rot_y));
        end
        // line points wrap to 24 bits
        if (r_state == S_LDX && w_div_done) begin
            r_px <= r_ax + (r_dx[24] ? -w_div_q[23:0] : w_div_q[23:0]);
        end
        if (r_state == S_LDY && w_div_done) begin
            r_py <= r_ay + (r_dy[24] ? -w_div_q[23:0] : w_div_q[23:0]);
        end
        if (w_emit) begin
            r_m_data <= {2'b00, w_full, w_idx, w_head_new, r_py, r_px};
            r_m_last <= (r_i == r_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_head    <= '0;
            r_next    <= NEXT_W'(1);
        end else begin
            if (w_emit) begin
                r_m_valid <= 1'b1;
                r_head    <= w_head_new;
                r_next    <= w_full ? NEXT_W'(CAPACITY) : r_next + NEXT_W'(1);
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

    a_next_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next != '0) && (r_next <= NEXT_W'(CAPACITY)))
        else $error("table index out of range");

    a_ovf_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[93]) |-> (o_m_tdata[92:80] == IDX_W'(CAPACITY - 1)))
        else $error("overflow point with wrong index");

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LOAD))
        else $error("request accepted without load");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ((r_i != 7'd0) && (r_i <= r_n) && (r_n <= 7'(MAX_STEPS))))
        else $error("point counter out of range");

endmodule
